// ----- hw/rtl/pffl_pkg.sv -----
// ----------------------------------------------------------------------------
// pffl_pkg: shared definitions for the page frame free list allocator
// Types, sizes and status codes used by the front end, the back end and the
// response queue.
// ----------------------------------------------------------------------------
package pffl_pkg;

   // Sizes of the free store and of the request limits.
   localparam int PAGE_COUNT  = 128;
   localparam int MAX_REQUEST = 64;
   localparam int PAGE_SHIFT  = 21;

   // Fixed field widths of the transactions.
   localparam int OP_W     = 2;
   localparam int NUM_W    = 7;
   localparam int PAGE_W   = 7;
   localparam int ADDR_W   = 48;
   localparam int STATUS_W = 3;

   // Free store indexing: an index addresses one entry, a count can also
   // hold the full depth.
   localparam int IDX_W = $clog2(PAGE_COUNT);
   localparam int CNT_W = $clog2(PAGE_COUNT + 1);

   // Command queue between the front and the back end.
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_LVL_W = $clog2(CMD_DEPTH + 1);

   // Response queue on the result side.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_LVL_W = $clog2(RSP_DEPTH + 1);

   // Operation codes of the request channel.
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

   // Status codes of the response channel.
   localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FREED    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_REINIT   = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [NUM_W-1:0]  page_count;
      logic [PAGE_W-1:0] page_number;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   granted_page;
      logic [ADDR_W-1:0]   page_address;
      logic                last;
   } rsp_type;

   // Classified command handed from the front to the back end.
   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_REINIT = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [NUM_W-1:0]  count;
      logic [PAGE_W-1:0] page;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_chan_type;

endpackage

// ----- hw/rtl/pffl_front.sv -----
// ----------------------------------------------------------------------------
// pffl_front: request intake and command queue
// Accepts request transactions, classifies the operation and holds the
// resulting commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module pffl_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  pffl_pkg::req_type      req_data,
   input  logic                   cmd_pop,
   output pffl_pkg::cmd_chan_type cmd_chan
);

   pffl_pkg::cmd_type                  queue_ff [pffl_pkg::CMD_DEPTH];
   logic [pffl_pkg::CMD_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pffl_pkg::CMD_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pffl_pkg::CMD_LVL_W-1:0]     level_ff, level_in;
   pffl_pkg::cmd_type                  cmd_new;
   logic                               cmd_known;
   logic                               accept;
   logic                               do_write;
   logic                               do_read;

   assign full   = (level_ff == pffl_pkg::CMD_LVL_W'(pffl_pkg::CMD_DEPTH));
   assign accept = push && !full;

   // Operation code 3 has no meaning: it is accepted and dropped.
   always_comb begin
      cmd_new.count = req_data.page_count;
      cmd_new.page  = req_data.page_number;
      cmd_new.kind  = pffl_pkg::CMD_ALLOC;
      cmd_known     = 1'b1;
      unique case (req_data.operation)
         pffl_pkg::OP_ALLOC:  cmd_new.kind = pffl_pkg::CMD_ALLOC;
         pffl_pkg::OP_FREE:   cmd_new.kind = pffl_pkg::CMD_FREE;
         pffl_pkg::OP_REINIT: cmd_new.kind = pffl_pkg::CMD_REINIT;
         default:             cmd_known    = 1'b0;
      endcase
   end

   assign do_write = accept && cmd_known;
   assign do_read  = cmd_pop && (level_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_write) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         level_in = level_ff + 1'b1;
      end else if (!do_write && do_read) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_chan.valid = (level_ff != '0);
   assign cmd_chan.cmd   = queue_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/pffl_back.sv -----
// ----------------------------------------------------------------------------
// pffl_back: free store and command execution
// Holds the free page stack and its count, executes one command at a time
// and streams granted pages with their physical addresses.
// ----------------------------------------------------------------------------
module pffl_back (
   input  logic                                clock,
   input  logic                                reset,
   input  pffl_pkg::cmd_chan_type              cmd_chan,
   output logic                                cmd_pop,
   input  logic [pffl_pkg::ADDR_W-1:0]         memory_base,
   input  logic [pffl_pkg::RSP_LVL_W-1:0]      rsp_level,
   output pffl_pkg::rsp_chan_type              rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_GRANT = 2'b10
   } back_state_type;

   back_state_type                       state_ff, state_in;
   logic [pffl_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [pffl_pkg::CNT_W-1:0]           idx_ff, idx_in;
   logic [pffl_pkg::CNT_W-1:0]           end_ff, end_in;

   logic [pffl_pkg::PAGE_W-1:0]          stack_mem [pffl_pkg::PAGE_COUNT];
   logic [pffl_pkg::PAGE_COUNT-1:0]      valid_ff;
   logic [pffl_pkg::PAGE_W-1:0]          rd_data_ff;
   logic [pffl_pkg::IDX_W-1:0]           rd_idx;
   logic [pffl_pkg::IDX_W-1:0]           wr_idx;
   logic                                 mem_we;
   logic                                 valid_clr;

   logic                                 issue;
   logic [pffl_pkg::STATUS_W-1:0]        iss_status;
   logic                                 iss_last;
   logic                                 iss_grant;

   logic                                 s1_valid_ff;
   logic [pffl_pkg::STATUS_W-1:0]        s1_status_ff;
   logic                                 s1_last_ff;
   logic                                 s1_grant_ff;
   logic                                 s1_hit_ff;
   logic [pffl_pkg::PAGE_W-1:0]          s1_dflt_ff;

   logic [pffl_pkg::RSP_LVL_W:0]         occupancy;
   logic                                 room;
   logic                                 grant_last;
   logic [pffl_pkg::PAGE_W-1:0]          page;

   // Results in flight plus results queued must leave space for one more.
   assign occupancy = {1'b0, rsp_level} + (pffl_pkg::RSP_LVL_W + 1)'(s1_valid_ff);
   assign room      = occupancy < (pffl_pkg::RSP_LVL_W + 1)'(pffl_pkg::RSP_DEPTH);

   assign rd_idx     = idx_ff[pffl_pkg::IDX_W-1:0];
   assign wr_idx     = count_ff[pffl_pkg::IDX_W-1:0];
   assign grant_last = ((idx_ff + 1'b1) == end_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      end_in     = end_ff;
      cmd_pop    = 1'b0;
      issue      = 1'b0;
      iss_status = pffl_pkg::STATUS_GRANTED;
      iss_last   = 1'b1;
      iss_grant  = 1'b0;
      mem_we     = 1'b0;
      valid_clr  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_chan.valid && room) begin
               cmd_pop = 1'b1;
               unique case (cmd_chan.cmd.kind)
                  pffl_pkg::CMD_ALLOC: begin
                     if (cmd_chan.cmd.count == '0) begin
                        issue      = 1'b1;
                        iss_status = pffl_pkg::STATUS_ZERO;
                     end else if ((cmd_chan.cmd.count >
                                   pffl_pkg::NUM_W'(pffl_pkg::MAX_REQUEST)) ||
                                  (pffl_pkg::CNT_W'(cmd_chan.cmd.count) > count_ff)) begin
                        issue      = 1'b1;
                        iss_status = pffl_pkg::STATUS_SHORT;
                     end else begin
                        idx_in   = count_ff - pffl_pkg::CNT_W'(cmd_chan.cmd.count);
                        end_in   = count_ff;
                        count_in = count_ff - pffl_pkg::CNT_W'(cmd_chan.cmd.count);
                        state_in = ST_GRANT;
                     end
                  end
                  pffl_pkg::CMD_FREE: begin
                     issue = 1'b1;
                     if (count_ff >= pffl_pkg::CNT_W'(pffl_pkg::PAGE_COUNT)) begin
                        iss_status = pffl_pkg::STATUS_REJECTED;
                     end else begin
                        iss_status = pffl_pkg::STATUS_FREED;
                        mem_we     = 1'b1;
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  pffl_pkg::CMD_REINIT: begin
                     issue      = 1'b1;
                     iss_status = pffl_pkg::STATUS_REINIT;
                     valid_clr  = 1'b1;
                     count_in   = pffl_pkg::CNT_W'(pffl_pkg::PAGE_COUNT);
                  end
                  default: begin
                     issue = 1'b0;
                  end
               endcase
            end
         end
         ST_GRANT: begin
            // While there is room, one page a cycle, from the deepest taken entry up to the old top.
            if (room) begin
               issue     = 1'b1;
               iss_grant = 1'b1;
               iss_last  = grant_last;
               idx_in    = idx_ff + 1'b1;
               if (grant_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= pffl_pkg::CNT_W'(pffl_pkg::PAGE_COUNT);
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      end_ff <= end_in;
   end

   // An entry that was never written since reset or reinitialize holds its
   // original page, which is the depth minus one minus its index.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (valid_clr) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_idx] <= cmd_chan.cmd.page;
      end
      rd_data_ff <= stack_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= iss_status;
      s1_last_ff   <= iss_last;
      s1_grant_ff  <= iss_grant;
      s1_hit_ff    <= valid_ff[rd_idx];
      s1_dflt_ff   <= pffl_pkg::PAGE_W'(pffl_pkg::IDX_W'(pffl_pkg::PAGE_COUNT - 1) - rd_idx);
   end

   assign page = s1_grant_ff ? (s1_hit_ff ? rd_data_ff : s1_dflt_ff) : '0;

   assign rsp_chan.valid             = s1_valid_ff;
   assign rsp_chan.data.status       = s1_status_ff;
   assign rsp_chan.data.granted_page = page;
   assign rsp_chan.data.page_address = s1_grant_ff ?
      memory_base + (pffl_pkg::ADDR_W'(page) << pffl_pkg::PAGE_SHIFT) : '0;
   assign rsp_chan.data.last         = s1_last_ff;

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (rsp_level < pffl_pkg::RSP_LVL_W'(pffl_pkg::RSP_DEPTH)))
      else $error("response pushed into a full response queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pffl_pkg::CNT_W'(pffl_pkg::PAGE_COUNT))
      else $error("free count above the store depth");

   a_grant_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GRANT) |-> ((idx_ff < end_ff) && (count_ff <= idx_ff)))
      else $error("grant index outside the taken window");

   a_last_ends_grant: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_grant_ff && s1_last_ff) |-> (state_ff == ST_IDLE))
      else $error("grant burst continued after its final page");

   a_idle_results_last: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_grant_ff) |-> s1_last_ff)
      else $error("single result without last flag");
`endif

endmodule

// ----- hw/rtl/pffl_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// pffl_rsp_queue: response queue
// Buffers results from the back end so that the consumer may stall while
// the back end keeps working.
// ----------------------------------------------------------------------------
module pffl_rsp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  pffl_pkg::rsp_chan_type          rsp_chan,
   input  logic                            pop,
   output logic                            empty,
   output pffl_pkg::rsp_type               rsp_data,
   output logic [pffl_pkg::RSP_LVL_W-1:0]  rsp_level
);

   pffl_pkg::rsp_type                  queue_ff [pffl_pkg::RSP_DEPTH];
   logic [pffl_pkg::RSP_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pffl_pkg::RSP_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pffl_pkg::RSP_LVL_W-1:0]     level_ff, level_in;
   logic                               do_write;
   logic                               do_read;

   // The back end only pushes when it has reserved a slot.
   assign do_write = rsp_chan.valid;
   assign do_read  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_write) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         level_in = level_ff + 1'b1;
      end else if (!do_write && do_read) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         queue_ff[wr_ptr_ff] <= rsp_chan.data;
      end
   end

   assign empty     = (level_ff == '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign rsp_level = level_ff;

endmodule

// ----- hw/rtl/page_frame_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator: LIFO page frame allocator
// Flow: a request passes the front end's command queue, then the back end,
// which registers each result once before the response queue takes it.
// The back end executes one command at a time and streams a grant's pages
// one read a cycle from its stack while the response queue has room.
// Reset: synchronous; the store holds every page with page 0 on top at once,
// with no clearing pass, and the base address register reads 0.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel: accepted when push is high and full is low.
   input  logic                          push,
   output logic                          full,
   input  pffl_pkg::req_type             req_data,
   // Result channel: accepted when pop is high and empty is low.
   output logic                          empty,
   input  logic                          pop,
   output pffl_pkg::rsp_type             rsp_data,
   // Configuration channel for the base address register.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pffl_pkg::ADDR_W-1:0]   csr_data
);

   // The user must write the base address only while the block is idle (the block
   // does not enforce this), so a plain register is enough; the write channel never stalls.
   logic [pffl_pkg::ADDR_W-1:0]        memory_base_ff;
   pffl_pkg::cmd_chan_type             cmd_chan;
   logic                               cmd_pop;
   pffl_pkg::rsp_chan_type             rsp_chan;
   logic [pffl_pkg::RSP_LVL_W-1:0]     rsp_level;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         memory_base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         memory_base_ff <= csr_data;
      end
   end

   // The front end takes request transactions, drops the unused operation
   // code and queues classified commands, so intake continues while the back
   // end is busy streaming a grant.
   pffl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_pop  (cmd_pop),
      .cmd_chan (cmd_chan)
   );

   // The back end owns the free stack and its count. It checks each command
   // against the current count, updates the store and emits results through
   // one registered stage, reserving a response slot before each issue.
   pffl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_chan    (cmd_chan),
      .cmd_pop     (cmd_pop),
      .memory_base (memory_base_ff),
      .rsp_level   (rsp_level),
      .rsp_chan    (rsp_chan)
   );

   // The response queue parts the back end from the consumer, so a stalled
   // consumer holds results without stopping the back end until it fills.
   pffl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_chan  (rsp_chan),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data),
      .rsp_level (rsp_level)
   );

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the page frame free list allocator
// A driver pushes request transactions from a pending queue and a monitor pops
// response transactions. Every accepted request runs through a bench-side
// model of the LIFO free store, and each popped response is checked field by
// field against the oldest predicted one. The base address register is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

   // The request encoding leaves one operation code unused; the block ignores it.
   localparam logic [pffl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 4;
   localparam int IDLE_MAX      = 12;
   // The pause before a register write or the end of the run covers the
   // deepest pipeline path with a wide margin.
   localparam int DRAIN_CYCLES  = 16;
   // The slowest correct run is far below this, even with 250 requests of 64
   // grants each and every response stalled for the longest idle gap.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 38;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          push      = 1'b0;
   logic                          full;
   pffl_pkg::req_type             req_data  = '0;
   logic                          empty;
   logic                          pop       = 1'b0;
   pffl_pkg::rsp_type             rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [pffl_pkg::ADDR_W-1:0]   csr_data  = '0;

   page_frame_free_list_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Stimulus waiting to be pushed, and the responses the model predicts.
   pffl_pkg::req_type pending_requests[$];
   pffl_pkg::rsp_type expected_responses[$];

   // Bench copy of the free store and of the base address register.
   logic [pffl_pkg::PAGE_W-1:0] free_pages [pffl_pkg::PAGE_COUNT];
   int                          free_total;
   logic [pffl_pkg::ADDR_W-1:0] base_address = '0;

   // Bookkeeping shared between the stimulus, the driver and the monitor.
   int requests_queued  = 0;
   int requests_sent    = 0;
   int responses_seen   = 0;
   int pages_granted    = 0;
   int base_settings    = 1;
   int error_count      = 0;
   int cycle_count      = 0;
   int send_idle_max    = IDLE_MAX;
   int recv_idle_max    = IDLE_MAX;
   int send_gap         = 0;
   int recv_gap         = 0;

   // The store restarts with every page free and page 0 on top, which is
   // the highest index.
   function automatic void refill_store();
      for (int i = 0; i < pffl_pkg::PAGE_COUNT; i++)
         free_pages[i] = pffl_pkg::PAGE_W'(pffl_pkg::PAGE_COUNT - 1 - i);
      free_total = pffl_pkg::PAGE_COUNT;
   endfunction

   initial refill_store();

   // Works out the responses that one accepted request transaction causes
   // and updates the bench copy of the store.
   function automatic void predict_request(pffl_pkg::req_type req);
      pffl_pkg::rsp_type           rsp;
      int                          wanted;
      int                          first;
      logic [pffl_pkg::ADDR_W-1:0] page_wide;
      rsp      = '0;
      rsp.last = 1'b1;
      wanted   = int'(req.page_count);
      case (req.operation)
         pffl_pkg::OP_ALLOC: begin
            if (wanted == 0) begin
               rsp.status = pffl_pkg::STATUS_ZERO;
               expected_responses.push_back(rsp);
            end else if (wanted > pffl_pkg::MAX_REQUEST || wanted > free_total) begin
               // A refused request leaves the store as it was.
               rsp.status = pffl_pkg::STATUS_SHORT;
               expected_responses.push_back(rsp);
            end else begin
               // The top pages are handed out deepest first, so the page that
               // was on top comes with the last flag.
               first = free_total - wanted;
               for (int k = 0; k < wanted; k++) begin
                  page_wide                       = '0;
                  page_wide[pffl_pkg::PAGE_W-1:0] = free_pages[first + k];
                  rsp.status       = pffl_pkg::STATUS_GRANTED;
                  rsp.granted_page = free_pages[first + k];
                  rsp.page_address = base_address + (page_wide << pffl_pkg::PAGE_SHIFT);
                  rsp.last         = (k == wanted - 1);
                  expected_responses.push_back(rsp);
               end
               free_total = first;
            end
         end
         pffl_pkg::OP_FREE: begin
            // Any page number is pushed as given; duplicates go unnoticed.
            if (free_total >= pffl_pkg::PAGE_COUNT) begin
               rsp.status = pffl_pkg::STATUS_REJECTED;
            end else begin
               free_pages[free_total] = req.page_number;
               free_total++;
               rsp.status = pffl_pkg::STATUS_FREED;
            end
            expected_responses.push_back(rsp);
         end
         pffl_pkg::OP_REINIT: begin
            refill_store();
            rsp.status = pffl_pkg::STATUS_REINIT;
            expected_responses.push_back(rsp);
         end
         OP_UNUSED: begin
            // Ignored by the block: no response, no change of state.
         end
      endcase
   endfunction

   // Compares one popped response transaction with the oldest prediction.
   function automatic void check_response(pffl_pkg::rsp_type got);
      pffl_pkg::rsp_type want;
      responses_seen++;
      if (expected_responses.size() == 0) begin
         $display("%0t: response with nothing expected, actual %p", $time, got);
         error_count++;
      end else begin
         want = expected_responses.pop_front();
         if (got.status == pffl_pkg::STATUS_GRANTED)
            pages_granted++;
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            error_count++;
         end
         if (got.granted_page !== want.granted_page) begin
            $display("%0t: granted_page mismatch, expected %0d, actual %0d",
                     $time, want.granted_page, got.granted_page);
            error_count++;
         end
         if (got.page_address !== want.page_address) begin
            $display("%0t: page_address mismatch, expected 0x%012h, actual 0x%012h",
                     $time, want.page_address, got.page_address);
            error_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, got.last);
            error_count++;
         end
      end
   endfunction

   // Driver. A request transaction completes at an edge with push high and
   // full low; the model sees it at that same edge. Before each new item the
   // driver idles for a freshly drawn number of cycles. Push gets exactly one
   // nonblocking assignment per edge, so back-to-back items keep it high.
   always @(posedge clock) begin
      logic next_push;
      if (reset) begin
         push     <= 1'b0;
         send_gap = 0;
      end else begin
         next_push = push && full;
         if (push && !full) begin
            predict_request(req_data);
            requests_sent++;
         end
         if (!next_push) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() != 0) begin
               req_data  <= pending_requests.pop_front();
               next_push = 1'b1;
               send_gap  = $urandom_range(0, send_idle_max);
            end
         end
         push <= next_push;
      end
   end

   // Monitor. A response transaction completes at an edge with pop high and
   // empty low. After each one the monitor stalls for a drawn number of
   // cycles before it pops again.
   always @(posedge clock) begin
      logic next_pop;
      if (reset) begin
         pop      <= 1'b0;
         recv_gap = 0;
      end else begin
         next_pop = pop;
         if (pop && !empty) begin
            check_response(rsp_data);
            recv_gap = $urandom_range(0, recv_idle_max);
            next_pop = (recv_gap == 0);
         end else if (!pop) begin
            if (recv_gap > 0)
               recv_gap--;
            next_pop = (recv_gap == 0);
         end
         pop <= next_pop;
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still expected",
                  cycle_count, expected_responses.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic queue_request(logic [pffl_pkg::OP_W-1:0] op, int count, int page);
      pffl_pkg::req_type req;
      req.operation   = op;
      req.page_count  = pffl_pkg::NUM_W'(count);
      req.page_number = pffl_pkg::PAGE_W'(page);
      pending_requests.push_back(req);
      requests_queued++;
   endtask

   // Returns once every queued request has been accepted and answered, then
   // lets the pipeline drain, since an ignored request leaves no trace.
   task automatic wait_idle();
      while (requests_sent != requests_queued || expected_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the base address register; only called while the block is idle.
   task automatic write_base(logic [pffl_pkg::ADDR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid    <= 1'b0;
      base_address = value;
      base_settings++;
   endtask

   // Random traffic: mostly small allocations and frees with random content,
   // some large or oversized requests, occasional reinitialize transactions
   // that refill the store, and a little noise with the unused code.
   task automatic queue_random(int useful_items);
      int pick;
      int done;
      done = 0;
      while (done < useful_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 25)
            queue_request(pffl_pkg::OP_ALLOC, $urandom_range(1, 4),
                          $urandom_range(0, 127));
         else if (pick < 33)
            queue_request(pffl_pkg::OP_ALLOC, $urandom_range(5, pffl_pkg::MAX_REQUEST),
                          $urandom_range(0, 127));
         else if (pick < 37)
            queue_request(pffl_pkg::OP_ALLOC, $urandom_range(0, 127),
                          $urandom_range(0, 127));
         else if (pick < 87)
            queue_request(pffl_pkg::OP_FREE, $urandom_range(0, 127),
                          $urandom_range(0, 127));
         else if (pick < 94)
            queue_request(pffl_pkg::OP_REINIT, $urandom_range(0, 127),
                          $urandom_range(0, 127));
         else
            queue_request(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127));
         if (pick < 94)
            done++;
      end
   endtask

   initial begin
      logic [pffl_pkg::ADDR_W-1:0] phase_base [RANDOM_PHASES];
      phase_base[0] = '0;
      phase_base[1] = pffl_pkg::ADDR_W'({$urandom(), $urandom()});
      phase_base[2] = '1;
      phase_base[3] = {1'b1, {(pffl_pkg::ADDR_W-1){1'b0}}};
      phase_base[4] = pffl_pkg::ADDR_W'({$urandom(), $urandom()});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first at the reset base of zero. It walks the store
      // from full to empty and back, hitting the zero request, requests over
      // the size limit, a request larger than what is free, a free into a
      // full store, the extreme page numbers and the ignored operation.
      queue_request(pffl_pkg::OP_ALLOC,  0,                         0);
      queue_request(pffl_pkg::OP_ALLOC,  pffl_pkg::MAX_REQUEST + 1, 127);
      queue_request(pffl_pkg::OP_ALLOC,  127,                       0);
      queue_request(pffl_pkg::OP_FREE,   0,                         5);
      queue_request(pffl_pkg::OP_ALLOC,  1,                         0);
      queue_request(pffl_pkg::OP_ALLOC,  pffl_pkg::MAX_REQUEST,     0);
      queue_request(pffl_pkg::OP_ALLOC,  pffl_pkg::MAX_REQUEST,     0);
      queue_request(pffl_pkg::OP_ALLOC,  63,                        0);
      queue_request(pffl_pkg::OP_ALLOC,  1,                         0);
      queue_request(pffl_pkg::OP_FREE,   0,                         127);
      queue_request(pffl_pkg::OP_FREE,   127,                       0);
      queue_request(pffl_pkg::OP_FREE,   0,                         'h55);
      queue_request(pffl_pkg::OP_FREE,   0,                         'h2A);
      queue_request(pffl_pkg::OP_ALLOC,  4,                         'h7F);
      queue_request(OP_UNUSED,           127,                       127);
      queue_request(pffl_pkg::OP_REINIT, 127,                       127);
      queue_request(pffl_pkg::OP_FREE,   127,                       127);
      wait_idle();

      // The same corners again with the base at all ones, so that the granted
      // address of every nonzero page wraps at 48 bits.
      write_base('1);
      queue_request(pffl_pkg::OP_ALLOC,  pffl_pkg::MAX_REQUEST, 0);
      queue_request(pffl_pkg::OP_ALLOC,  2,                     0);
      queue_request(pffl_pkg::OP_FREE,   0,                     127);
      queue_request(pffl_pkg::OP_REINIT, 0,                     0);
      queue_request(pffl_pkg::OP_FREE,   0,                     0);
      queue_request(pffl_pkg::OP_ALLOC,  0,                     127);
      wait_idle();

      // Random phases, each under its own base address and idling style:
      // both sides idle, neither idles, or only one of them does.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_base(phase_base[p]);
         case (p)
            2:       begin send_idle_max = 0;        recv_idle_max = 0;        end
            3:       begin send_idle_max = IDLE_MAX; recv_idle_max = 0;        end
            4:       begin send_idle_max = 0;        recv_idle_max = IDLE_MAX; end
            default: begin send_idle_max = IDLE_MAX; recv_idle_max = IDLE_MAX; end
         endcase
         queue_random(PHASE_ITEMS);
         wait_idle();
      end

      $display("Checked %0d responses, %0d of them granted pages, from %0d requests",
               responses_seen, pages_granted, requests_sent);
      $display("across %0d base address settings; %0d mismatches",
               base_settings, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
